@@ rtl/keyed_ordered_table_macros.svh @@
// Assertion macros for the keyed ordered table RTL.
`ifndef KEYED_ORDERED_TABLE_MACROS_SVH
`define KEYED_ORDERED_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle whenever ante holds.
`define KOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyed_ordered_table: assertion failed");

// Check that cons holds in the cycle after ante holds.
`define KOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyed_ordered_table: assertion failed");

`else

`define KOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/kot_pkg.sv @@
// Types, constants and codes of the keyed ordered table.
`default_nettype none

package kot_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int KEY_W       = 8;
	localparam int COUNT_W     = 8;
	localparam int POS_W       = 4;
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
	localparam int SEL_W       = (USED_W > POS_W) ? USED_W : POS_W;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [USED_W-1:0]  used_t;
	typedef logic [SEL_W-1:0]   sel_t;
	typedef logic [1:0]         cmd_t;

	localparam used_t  USED_FULL   = used_t'(TABLE_DEPTH);
	localparam count_t LIMIT_RESET = count_t'(20);

	// Command codes; code 3 is ignored.
	localparam cmd_t CMD_APPEND = 2'd0;
	localparam cmd_t CMD_CHANGE = 2'd1;
	localparam cmd_t CMD_READ   = 2'd2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OVER_LIMIT = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_FULL       = 3'd3,
		ST_EMPTY_POS  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FINISH
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic   start;
		logic   append;
		logic   remove;
		key_t   key;
		count_t count;
		used_t  used;
	} cell_ctl_t;

	// Search outcome reported by each cell.
	typedef struct packed {
		logic tok;
		logic hit;
		logic miss;
	} cell_stat_t;

endpackage

`default_nettype wire

@@ rtl/kot_cell.sv @@
// One table cell: holds an entry, passes the search token and takes its neighbor's entry.
`default_nettype none

module kot_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire kot_pkg::used_t        cell_idx,
	input  wire kot_pkg::cell_ctl_t    ctl,
	input  wire logic                  tok_in,
	input  wire kot_pkg::key_t         nxt_key,
	input  wire kot_pkg::count_t       nxt_count,
	output logic                       tok_out,
	output kot_pkg::key_t              key,
	output kot_pkg::count_t            count,
	output kot_pkg::cell_stat_t        stat
);

	kot_pkg::key_t   key_q;
	kot_pkg::count_t count_q;
	logic            tok_q;
	logic            passed_q;
	logic            in_use;
	logic            match;
	logic            hit;

	// Classify the token held in this cell
	assign in_use  = cell_idx < ctl.used;
	assign match   = key_q == ctl.key;
	assign hit     = tok_q && in_use && match;
	assign tok_out = tok_q && in_use && !match;

	assign stat.tok  = tok_q;
	assign stat.hit  = hit;
	assign stat.miss = tok_q && !in_use;

	assign key   = key_q;
	assign count = count_q;

	// Write at the tail, shift up behind a removed entry, or overwrite the count
	always_ff @(posedge clk) begin
		if (ctl.append && (cell_idx == ctl.used)) begin
			key_q   <= ctl.key;
			count_q <= ctl.count;
		end else if (ctl.remove && !passed_q) begin
			key_q   <= nxt_key;
			count_q <= nxt_count;
		end else if (hit && (ctl.count != '0)) begin
			count_q <= ctl.count;
		end
	end

	// Advance the token; mark cells it has gone through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			passed_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (ctl.start) begin
				passed_q <= 1'b0;
			end else if (tok_out) begin
				passed_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/keyed_ordered_table.sv @@
// Top level of the keyed ordered table: controller, cell chain and result register.
//
// Usage: commands arrive on the in channel (in_valid / in_stall), one result word per
// command leaves on the out channel (out_valid / out_stall). A word moves at a clock
// edge with valid high and stall low. The count limit is written on the cfg channel
// (cfg_valid / cfg_ready, ready is always high); the user must write it only while no
// command is in flight, as the block itself does not enforce this. The table is a chain
// of cells; a change command sends a search token from the head cell down the chain,
// one cell per cycle, and a removal shifts all later cells up by one at once, each cell
// taking its neighbor's entry. A command passes the execute state and then the finish
// state, which loads the output register; a change within the limit scans in between
// until the token reaches the matching entry, the first unused cell or the chain's end.
// One command is in flight at a time; the next one is taken at the edge after out_valid
// rises. It is taken while the previous result still sits in the output register.
// If the receiver stalls with a result waiting, the next result is held inside until
// the output register frees up. Reset empties the table and sets the limit to 20.
`default_nettype none

`include "keyed_ordered_table_macros.svh"

module keyed_ordered_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [7:0]  entry_key,
	input  wire logic [7:0]  entry_count,
	input  wire logic [3:0]  position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [4:0]       entries_used,
	output logic [7:0]       read_key,
	output logic [7:0]       read_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	localparam int DEPTH = kot_pkg::TABLE_DEPTH;

	kot_pkg::state_t     state_q, state_d;
	kot_pkg::cmd_t       op_cmd_q;
	kot_pkg::key_t       op_key_q;
	kot_pkg::count_t     op_count_q;
	logic [3:0]          op_pos_q;
	kot_pkg::count_t     limit_q;
	kot_pkg::used_t      used_q, used_d;

	kot_pkg::status_t    res_status_q, res_status_d;
	kot_pkg::key_t       res_key_q, res_key_d;
	kot_pkg::count_t     res_count_q, res_count_d;
	logic                res_load;

	logic                out_valid_q;
	kot_pkg::status_t    out_status_q;
	kot_pkg::used_t      out_used_q;
	kot_pkg::key_t       out_key_q;
	kot_pkg::count_t     out_count_q;
	logic                out_load;

	kot_pkg::cell_ctl_t  ctl;
	kot_pkg::cell_stat_t stat [DEPTH];
	kot_pkg::key_t       cell_key [DEPTH];
	kot_pkg::count_t     cell_count [DEPTH];
	logic [DEPTH:0]      tok_link;
	logic [DEPTH-1:0]    tok_vec;
	logic [DEPTH-1:0]    hit_vec;
	logic [DEPTH-1:0]    miss_vec;
	logic                hit_any;
	logic                miss_any;
	logic                over_limit;
	logic                pos_valid;
	kot_pkg::key_t       rd_key;
	kot_pkg::count_t     rd_count;
	logic                in_accept;

	// Channel handshakes
	assign in_stall   = state_q != kot_pkg::S_IDLE;
	assign in_accept  = in_valid && !in_stall;
	assign cfg_ready  = 1'b1;

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign entries_used = 5'(out_used_q);
	assign read_key     = out_key_q;
	assign read_count   = out_count_q;

	// Cell chain
	assign tok_link[0] = ctl.start;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		kot_pkg::key_t   nk;
		kot_pkg::count_t nc;

		if (i == DEPTH - 1) begin : g_tail
			assign nk = cell_key[i];
			assign nc = cell_count[i];
		end else begin : g_body
			assign nk = cell_key[i+1];
			assign nc = cell_count[i+1];
		end

		kot_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (kot_pkg::used_t'(i)),
			.ctl       (ctl),
			.tok_in    (tok_link[i]),
			.nxt_key   (nk),
			.nxt_count (nc),
			.tok_out   (tok_link[i+1]),
			.key       (cell_key[i]),
			.count     (cell_count[i]),
			.stat      (stat[i])
		);

		assign tok_vec[i]  = stat[i].tok;
		assign hit_vec[i]  = stat[i].hit;
		assign miss_vec[i] = stat[i].miss;
	end

	assign hit_any  = |hit_vec;
	assign miss_any = (|miss_vec) || tok_link[DEPTH];

	// Select the entry at the read position
	always_comb begin
		rd_key   = '0;
		rd_count = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (kot_pkg::sel_t'(op_pos_q) == kot_pkg::sel_t'(i)) begin
				rd_key   = cell_key[i];
				rd_count = cell_count[i];
			end
		end
	end

	assign over_limit = op_count_q > limit_q;
	assign pos_valid  = kot_pkg::sel_t'(op_pos_q) < kot_pkg::sel_t'(used_q);

	// Next state, cell commands and result
	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		ctl.start    = 1'b0;
		ctl.append   = 1'b0;
		ctl.remove   = 1'b0;
		ctl.key      = op_key_q;
		ctl.count    = op_count_q;
		ctl.used     = used_q;
		res_load     = 1'b0;
		res_status_d = kot_pkg::ST_OK;
		res_key_d    = '0;
		res_count_d  = '0;
		out_load     = 1'b0;
		case (state_q)
			kot_pkg::S_IDLE: begin
				if (in_accept) begin
					state_d = kot_pkg::S_EXEC;
				end
			end
			kot_pkg::S_EXEC: begin
				res_load = 1'b1;
				state_d  = kot_pkg::S_FINISH;
				case (op_cmd_q)
					kot_pkg::CMD_APPEND: begin
						if (over_limit) begin
							res_status_d = kot_pkg::ST_OVER_LIMIT;
						end else if (used_q >= kot_pkg::USED_FULL) begin
							res_status_d = kot_pkg::ST_FULL;
						end else begin
							ctl.append = 1'b1;
							used_d     = used_q + 1'b1;
						end
					end
					kot_pkg::CMD_CHANGE: begin
						if (over_limit) begin
							res_status_d = kot_pkg::ST_OVER_LIMIT;
						end else begin
							res_load  = 1'b0;
							ctl.start = 1'b1;
							state_d   = kot_pkg::S_SCAN;
						end
					end
					kot_pkg::CMD_READ: begin
						if (pos_valid) begin
							res_key_d   = rd_key;
							res_count_d = rd_count;
						end else begin
							res_status_d = kot_pkg::ST_EMPTY_POS;
						end
					end
					default: begin
						res_status_d = kot_pkg::ST_OK;
					end
				endcase
			end
			kot_pkg::S_SCAN: begin
				if (hit_any) begin
					res_load = 1'b1;
					state_d  = kot_pkg::S_FINISH;
					if (op_count_q == '0) begin
						ctl.remove = 1'b1;
						used_d     = used_q - 1'b1;
					end
				end else if (miss_any) begin
					res_load     = 1'b1;
					res_status_d = kot_pkg::ST_NOT_FOUND;
					state_d      = kot_pkg::S_FINISH;
				end
			end
			kot_pkg::S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = kot_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kot_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kot_pkg::S_IDLE;
			used_q      <= '0;
			limit_q     <= kot_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the command, the pending result and the output word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_cmd_q   <= cmd;
			op_key_q   <= entry_key;
			op_count_q <= entry_count;
			op_pos_q   <= position;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_key_q    <= res_key_d;
			res_count_q  <= res_count_d;
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_used_q   <= used_q;
			out_key_q    <= res_key_q;
			out_count_q  <= res_count_q;
		end
	end

	`KOT_ASSERT_IMP(a_tok_single, clk, arst_n, 1'b1, $onehot0(tok_vec))
	`KOT_ASSERT_IMP(a_scan_tok, clk, arst_n, state_q == kot_pkg::S_SCAN, $onehot(tok_vec))
	`KOT_ASSERT_IMP(a_hit_miss, clk, arst_n, 1'b1, !(hit_any && miss_any))
	`KOT_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= kot_pkg::USED_FULL)
	`KOT_ASSERT_NXT(a_finish_used, clk, arst_n, state_q == kot_pkg::S_FINISH, $stable(used_q))

endmodule

`default_nettype wire

@@ tb/tb_keyed_ordered_table.sv @@
// Self-checking testbench for the keyed ordered table: directed plan, random phases, scoreboard.
`default_nettype none

module tb_keyed_ordered_table;
	import kot_pkg::*;

	// Command code 3 is not named in the package; the block ignores it.
	localparam cmd_t CMD_IGNORED = 2'd3;
	localparam int   PLAN_ROWS   = 25;
	localparam int   PHASE_ITEMS = 160;
	localparam int   DRAIN_WAIT  = 3 + TABLE_DEPTH + 16;

	typedef struct packed {
		status_t st;
		used_t   used;
		key_t    rkey;
		count_t  rcount;
	} table_result_t;

	typedef struct packed {
		cmd_t          cmd;
		key_t          key;
		count_t        count;
		logic [3:0]    pos;
		logic [4:0]    reps;
		logic          fixed;
		table_result_t res;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	cmd_t       cmd = CMD_IGNORED;
	key_t       entry_key = '0;
	count_t     entry_count = '0;
	logic [3:0] position = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] status;
	logic [4:0] entries_used;
	logic [7:0] read_key;
	logic [7:0] read_count;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	// Shadow copy of the table and its limit
	key_t   shadow_key [TABLE_DEPTH];
	count_t shadow_count [TABLE_DEPTH];
	used_t  shadow_used = '0;
	count_t shadow_limit = LIMIT_RESET;

	table_result_t pending_words[$];
	plan_row_t     plan [PLAN_ROWS];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int words_checked = 0;
	int status_seen [5];
	int mid_limit = 0;

	keyed_ordered_table uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.entry_key    (entry_key),
		.entry_count  (entry_count),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.entries_used (entries_used),
		.read_key     (read_key),
		.read_count   (read_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow table and return the word it should produce.
	function automatic table_result_t apply_command(cmd_t c, key_t k, count_t n, logic [3:0] p);
		table_result_t r;
		int hit;
		r.st = ST_OK;
		r.rkey = '0;
		r.rcount = '0;
		hit = -1;
		case (c)
			CMD_APPEND: begin
				if (n > shadow_limit) begin
					r.st = ST_OVER_LIMIT;
				end else if (shadow_used == USED_FULL) begin
					r.st = ST_FULL;
				end else begin
					shadow_key[shadow_used] = k;
					shadow_count[shadow_used] = n;
					shadow_used = shadow_used + 1'b1;
				end
			end
			CMD_CHANGE: begin
				if (n > shadow_limit) begin
					r.st = ST_OVER_LIMIT;
				end else begin
					// first match nearest the head wins
					for (int i = 0; i < int'(shadow_used); i++) begin
						if (hit < 0 && shadow_key[i] == k) hit = i;
					end
					if (hit < 0) begin
						r.st = ST_NOT_FOUND;
					end else if (n == '0) begin
						for (int j = hit; j < int'(shadow_used) - 1; j++) begin
							shadow_key[j] = shadow_key[j + 1];
							shadow_count[j] = shadow_count[j + 1];
						end
						shadow_used = shadow_used - 1'b1;
					end else begin
						shadow_count[hit] = n;
					end
				end
			end
			CMD_READ: begin
				if (used_t'(p) < shadow_used) begin
					r.rkey = shadow_key[p];
					r.rcount = shadow_count[p];
				end else begin
					r.st = ST_EMPTY_POS;
				end
			end
			default: ;
		endcase
		r.used = shadow_used;
		return r;
	endfunction

	// Present one command, hold it until taken, then queue its expected word.
	task automatic send_command(input cmd_t c, input key_t k, input count_t n,
			input logic [3:0] p, input logic use_fixed, input table_result_t fixed_res);
		table_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		entry_key <= k;
		entry_count <= n;
		position <= p;
		do @(posedge clk); while (in_stall);
		predicted = apply_command(c, k, n, p);
		pending_words.push_back(use_fixed ? fixed_res : predicted);
		items_sent++;
	endtask

	// Pick a count: mostly legal under the current limit, sometimes anything.
	function automatic count_t pick_count();
		int roll;
		roll = $urandom_range(99);
		if (roll < 25) return '0;
		if (roll < 85) return count_t'($urandom_range(int'(shadow_limit)));
		return count_t'($urandom_range(255));
	endfunction

	// Build one random command biased toward hits on keys in use.
	task automatic send_random(input int append_pct);
		cmd_t       c;
		key_t       k;
		count_t     n;
		logic [3:0] p;
		int         roll;
		int         key_roll;
		roll = $urandom_range(99);
		key_roll = $urandom_range(99);
		p = 4'($urandom_range(15));
		if (key_roll < 45) k = key_t'($urandom_range(7));
		else if (key_roll < 55) k = (key_roll[0]) ? 8'hFF : 8'h00;
		else k = key_t'($urandom_range(255));
		n = pick_count();
		if (roll < append_pct) begin
			c = CMD_APPEND;
		end else if (roll < append_pct + 35) begin
			c = CMD_CHANGE;
			if (shadow_used != '0 && $urandom_range(99) < 65)
				k = shadow_key[$urandom_range(int'(shadow_used) - 1)];
			if ($urandom_range(99) < 40) n = '0;
		end else if (roll < 95) begin
			c = CMD_READ;
			if (shadow_used != '0 && $urandom_range(99) < 70)
				p = 4'($urandom_range(int'(shadow_used) - 1));
		end else begin
			c = CMD_IGNORED;
		end
		send_command(c, k, n, p, 1'b0, '0);
	endtask

	// Drop valid and wait for every outstanding word to come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// Write the count limit; only called with nothing in flight.
	task automatic write_limit(input count_t value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_limit = value;
	endtask

	// Check each word taken by the receiver, then choose next cycle's stall.
	always @(posedge clk) begin
		table_result_t want;
		if (out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word: status %0d, entries_used %0d", status,
					entries_used);
				mismatch_count++;
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (status < 5) status_seen[status]++;
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatch_count++;
				end
				if (entries_used !== want.used) begin
					$error("entries_used: expected %0d, got %0d", want.used, entries_used);
					mismatch_count++;
				end
				if (read_key !== want.rkey) begin
					$error("read_key: expected %0d, got %0d", want.rkey, read_key);
					mismatch_count++;
				end
				if (read_count !== want.rcount) begin
					$error("read_count: expected %0d, got %0d", want.rcount, read_count);
					mismatch_count++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		// Directed plan at the reset limit of 20; fixed rows carry their word inline.
		plan = '{
			'{CMD_READ,    8'h00, 8'd0,   4'd0,  5'd1,  1'b1, '{ST_EMPTY_POS,  5'd0,  8'd0, 8'd0}},
			'{CMD_CHANGE,  8'h05, 8'd3,   4'd0,  5'd1,  1'b1, '{ST_NOT_FOUND,  5'd0,  8'd0, 8'd0}},
			'{CMD_APPEND,  8'h00, 8'd21,  4'd0,  5'd1,  1'b1, '{ST_OVER_LIMIT, 5'd0,  8'd0, 8'd0}},
			'{CMD_APPEND,  8'hFF, 8'd255, 4'd0,  5'd1,  1'b1, '{ST_OVER_LIMIT, 5'd0,  8'd0, 8'd0}},
			'{CMD_IGNORED, 8'hFF, 8'd255, 4'd15, 5'd1,  1'b1, '{ST_OK,         5'd0,  8'd0, 8'd0}},
			'{CMD_APPEND,  8'h00, 8'd0,   4'd0,  5'd1,  1'b1, '{ST_OK,         5'd1,  8'd0, 8'd0}},
			'{CMD_APPEND,  8'hFF, 8'd20,  4'd0,  5'd1,  1'b1, '{ST_OK,         5'd2,  8'd0, 8'd0}},
			'{CMD_APPEND,  8'hA5, 8'd7,   4'd0,  5'd1,  1'b0, '0},
			'{CMD_APPEND,  8'hFF, 8'd3,   4'd0,  5'd1,  1'b0, '0},
			'{CMD_READ,    8'h00, 8'd0,   4'd1,  5'd1,  1'b0, '0},
			'{CMD_CHANGE,  8'hFF, 8'd21,  4'd0,  5'd1,  1'b1, '{ST_OVER_LIMIT, 5'd4,  8'd0, 8'd0}},
			'{CMD_CHANGE,  8'hFF, 8'd9,   4'd0,  5'd1,  1'b0, '0},
			'{CMD_READ,    8'h00, 8'd0,   4'd1,  5'd1,  1'b0, '0},
			'{CMD_READ,    8'h00, 8'd0,   4'd3,  5'd1,  1'b0, '0},
			'{CMD_CHANGE,  8'hFF, 8'd0,   4'd0,  5'd1,  1'b0, '0},
			'{CMD_READ,    8'h00, 8'd0,   4'd1,  5'd1,  1'b0, '0},
			'{CMD_READ,    8'h00, 8'd0,   4'd15, 5'd1,  1'b1, '{ST_EMPTY_POS,  5'd3,  8'd0, 8'd0}},
			'{CMD_CHANGE,  8'h5A, 8'd1,   4'd0,  5'd1,  1'b1, '{ST_NOT_FOUND,  5'd3,  8'd0, 8'd0}},
			'{CMD_APPEND,  8'h11, 8'd1,   4'd0,  5'd13, 1'b0, '0},
			'{CMD_APPEND,  8'h22, 8'd0,   4'd0,  5'd1,  1'b1, '{ST_FULL,       5'd16, 8'd0, 8'd0}},
			'{CMD_APPEND,  8'h22, 8'd21,  4'd0,  5'd1,  1'b1, '{ST_OVER_LIMIT, 5'd16, 8'd0, 8'd0}},
			'{CMD_READ,    8'h00, 8'd0,   4'd15, 5'd1,  1'b0, '0},
			'{CMD_CHANGE,  8'h00, 8'd0,   4'd0,  5'd1,  1'b0, '0},
			'{CMD_CHANGE,  8'h11, 8'd0,   4'd0,  5'd1,  1'b0, '0},
			'{CMD_READ,    8'h00, 8'd0,   4'd0,  5'd1,  1'b0, '0}
		};
		mid_limit = $urandom_range(254, 1);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan
		for (int r = 0; r < PLAN_ROWS; r++) begin
			for (int k = 0; k < int'(plan[r].reps); k++)
				send_command(plan[r].cmd, plan[r].key, plan[r].count, plan[r].pos,
					plan[r].fixed, plan[r].res);
		end
		drain();

		// Random phases: each sets a new limit and a new pacing mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_limit(8'd255);
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					write_limit(8'd0);
					send_idle_pct = 52;
					stall_pct = 0;
				end
				2: begin
					write_limit(count_t'(mid_limit));
					send_idle_pct = 0;
					stall_pct = 52;
				end
				default: begin
					write_limit(LIMIT_RESET);
					send_idle_pct = 27;
					stall_pct = 27;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random((ph == 0) ? 45 : (ph == 1) ? 30 : (ph == 2) ? 25 : 40);
			drain();
		end

		// Let the block settle, then look for leftovers
		stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d expected words never arrived", pending_words.size());
			mismatch_count++;
		end
		$display("Ran %0d commands and compared %0d words under limits 20, 255, 0 and %0d.",
			items_sent, words_checked, mid_limit);
		$display("Status counts: ok %0d, over limit %0d, not found %0d, full %0d, empty %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
